FILE: rtl/ert_pkg.sv
`timescale 1ns / 1ps

package ert_pkg;

  // Configuration defaults and limits
  localparam int unsigned DEFAULT_CHANNELS  = 6;
  localparam int unsigned DEFAULT_TIME_BITS = 32;
  localparam int unsigned MAX_CHANNELS      = 8;
  localparam int unsigned MASK_W            = 6;
  localparam int unsigned CMD_W             = 2;
  localparam int unsigned DIST_W            = 15;

  // Distance scaling: mm = floor(elapsed * 343 / 2000), saturated
  localparam int unsigned SOUND_SPEED = 343;
  localparam int unsigned ROUND_TRIP  = 2;
  localparam int unsigned MM_PER_M    = 1000;
  localparam int unsigned SCALE_DIV   = ROUND_TRIP * MM_PER_M;
  localparam int unsigned DIST_MAX    = (1 << DIST_W) - 1;

  // Smallest elapsed time whose distance exceeds DIST_MAX
  localparam int unsigned SAT_LIMIT =
    ((DIST_MAX + 1) * SCALE_DIV + SOUND_SPEED - 1) / SOUND_SPEED;
  localparam int unsigned ELAPSED_W = $clog2(SAT_LIMIT);
  localparam int unsigned SPEED_W   = $clog2(SOUND_SPEED + 1);
  localparam int unsigned PROD_W    = ELAPSED_W + SPEED_W;

  // 2000 = 16 * 125: shift out the power of two, then scale by 1/125
  localparam int unsigned PRE_SHIFT   = 4;
  localparam int unsigned ODD_DIV     = SCALE_DIV >> PRE_SHIFT;
  localparam int unsigned QUOT_W      = PROD_W - PRE_SHIFT;
  localparam int unsigned RECIP_SHIFT = 29;
  localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + ODD_DIV - 1) / ODD_DIV;
  localparam int unsigned RECIP_W     = $clog2(RECIP + 1);
  localparam int unsigned FULL_W      = QUOT_W + RECIP_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_ARM  = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [MASK_W-1:0] echo_levels;
    logic [MASK_W-1:0] module_mask;
  } ert_in_t;

  typedef struct packed {
    logic              ready_res;
    logic [DIST_W-1:0] distance_mm;
  } ert_out_t;

  // Channel stage result handed to the scaling pipeline
  typedef struct packed {
    logic                 valid;
    logic                 ready;
    logic                 sat;
    logic [ELAPSED_W-1:0] elapsed;
  } ert_sel_t;

endpackage

FILE: rtl/ert_channels.sv
`timescale 1ns / 1ps

module ert_channels import ert_pkg::*; #(
  parameter int unsigned CHANNELS  = DEFAULT_CHANNELS,
  parameter int unsigned TIME_BITS = DEFAULT_TIME_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     valid_i,
  input  ert_in_t  item_i,
  output ert_sel_t sel_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ARMED   = 2'd1,
    PH_STARTED = 2'd2,
    PH_DONE    = 2'd3
  } phase_e;

  phase_e               phase_q [CHANNELS];
  phase_e               phase_d [CHANNELS];
  logic [TIME_BITS-1:0] start_q [CHANNELS];
  logic [TIME_BITS-1:0] end_q   [CHANNELS];
  logic [CHANNELS-1:0]  cap_start, cap_end;
  logic [TIME_BITS-1:0] cnt_q, cnt_d;

  logic [MAX_CHANNELS-1:0] levels, mask;
  logic                    do_it;
  logic                    any_sel;
  logic [IdxW-1:0]         sel_idx;
  logic [TIME_BITS-1:0]    elapsed;
  logic [31:0]             elapsed_w;
  ert_sel_t                sel_d, sel_q;
  logic                    sel_valid_q;

  assign levels = MAX_CHANNELS'(item_i.echo_levels);
  assign mask   = MAX_CHANNELS'(item_i.module_mask);
  assign do_it  = adv_i && valid_i;

  // Next phase and capture strobes for every channel
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < CHANNELS; i++) begin
      phase_d[i]   = phase_q[i];
      cap_start[i] = 1'b0;
      cap_end[i]   = 1'b0;
    end
    unique case (cmd_e'(item_i.command))
      CMD_TICK: begin
        cnt_d = cnt_q + 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
          if (levels[i] && phase_q[i] == PH_ARMED) begin
            phase_d[i]   = PH_STARTED;
            cap_start[i] = 1'b1;
          end else if (!levels[i] && phase_q[i] == PH_STARTED) begin
            phase_d[i] = PH_DONE;
            cap_end[i] = 1'b1;
          end
        end
      end
      CMD_ARM: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (mask[i]) phase_d[i] = PH_ARMED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < CHANNELS; i++) phase_q[i] <= PH_IDLE;
    end else if (do_it) begin
      cnt_q <= cnt_d;
      for (int i = 0; i < CHANNELS; i++) phase_q[i] <= phase_d[i];
    end
  end

  // Time stamps need no reset: a channel is only read once both are written
  always_ff @(posedge clk_i) begin
    if (do_it) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (cap_start[i]) start_q[i] <= cnt_d;
        if (cap_end[i])   end_q[i]   <= cnt_d;
      end
    end
  end

  // Lowest selected channel
  always_comb begin
    any_sel = 1'b0;
    sel_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        any_sel = 1'b1;
        sel_idx = IdxW'(i);
      end
    end
  end

  assign elapsed   = end_q[sel_idx] - start_q[sel_idx];
  assign elapsed_w = 32'(elapsed);

  always_comb begin
    sel_d.valid   = valid_i;
    sel_d.ready   = (cmd_e'(item_i.command) == CMD_READ) && any_sel
                    && (phase_q[sel_idx] == PH_DONE);
    sel_d.sat     = (elapsed_w >= 32'(SAT_LIMIT));
    sel_d.elapsed = elapsed_w[ELAPSED_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
    end else if (adv_i) begin
      sel_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) sel_q <= sel_d;
  end

  always_comb begin
    sel_o       = sel_q;
    sel_o.valid = sel_valid_q;
  end

endmodule

FILE: rtl/ert_scale.sv
`timescale 1ns / 1ps

module ert_scale import ert_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  ert_sel_t sel_i,
  output logic     valid_o,
  output ert_out_t data_o
);

  logic              mul_valid_q;
  logic              mul_ready_q, mul_sat_q;
  logic [PROD_W-1:0] prod_q;
  logic [QUOT_W-1:0] quot_in;
  logic [FULL_W-1:0] full;
  logic [DIST_W-1:0] scaled_mm;
  logic              out_valid_q;
  ert_out_t          out_q;

  // Stage one: elapsed * speed of sound
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      mul_valid_q <= sel_i.valid;
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mul_ready_q <= sel_i.ready;
      mul_sat_q   <= sel_i.sat;
      prod_q      <= PROD_W'(sel_i.elapsed) * PROD_W'(SOUND_SPEED);
    end
  end

  // Stage two: drop the factor 16, then multiply by the reciprocal of 125
  assign quot_in   = prod_q[PROD_W-1:PRE_SHIFT];
  assign full      = FULL_W'(quot_in) * FULL_W'(RECIP);
  assign scaled_mm = full[RECIP_SHIFT +: DIST_W];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q.ready_res <= mul_ready_q;
      if (!mul_ready_q)   out_q.distance_mm <= '0;
      else if (mul_sat_q) out_q.distance_mm <= DIST_W'(DIST_MAX);
      else                out_q.distance_mm <= scaled_mm;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

FILE: rtl/multi_channel_echo_ranging_timer_top.sv
`timescale 1ns / 1ps

// Multi-channel ultrasonic echo timer. Each item is a tick, an arm or a read
// command, and each item yields exactly one result item. A tick advances the
// microsecond tick counter and samples every channel's echo level: an
// armed channel seeing high stamps its start time, a started channel seeing
// low stamps its end time and is done. Arm sets every selected channel armed.
// Read reports the lowest selected channel: when it is done, ready_res is 1
// and distance_mm = floor(elapsed * 343 / 2000), saturated at 32767, with the
// elapsed time taken modulo the counter width; otherwise both fields are 0.
// Throughput is one item per cycle while the output is not held. From
// acceptance to the output port an item passes the input register, then the
// channel state and selection, the speed-of-sound multiply, and the
// divide-by-2000 reciprocal multiply feeding the output register. The whole
// pipeline advances together and holds only while a result sits unaccepted at
// the output.

module multi_channel_echo_ranging_timer_top import ert_pkg::*; #(
  parameter int unsigned CHANNELS  = DEFAULT_CHANNELS,
  parameter int unsigned TIME_BITS = DEFAULT_TIME_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ert_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ert_out_t out_data_o
);

  logic     adv;
  logic     in_valid_q;
  ert_in_t  in_q;
  ert_sel_t sel;

  // Advance every stage unless a finished item waits at the output
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) in_q <= in_data_i;
  end

  // Channel state, time stamps and read selection
  ert_channels #(
    .CHANNELS  (CHANNELS),
    .TIME_BITS (TIME_BITS)
  ) u_channels (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_q),
    .item_i  (in_q),
    .sel_o   (sel)
  );

  // Distance scaling and output register
  ert_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .sel_i   (sel),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule
